>>> rtl/oaps_pkg.sv
// Shared types and constants for the open-addressing pointer set.
// No dependencies; imported by oaps_ctrl, oaps_dpath and the top level.
package oaps_pkg;

  // item commands
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  // result status codes
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_ALREADY  = 3'd1;
  localparam logic [2:0] ST_PRESENT  = 3'd2;
  localparam logic [2:0] ST_ABSENT   = 3'd3;
  localparam logic [2:0] ST_REMOVED  = 3'd4;
  localparam logic [2:0] ST_ZERO     = 3'd5;
  localparam logic [2:0] ST_FULL     = 3'd6;

  // slot tags
  localparam logic [1:0] TAG_EMPTY = 2'd0;
  localparam logic [1:0] TAG_LIVE  = 2'd1;
  localparam logic [1:0] TAG_TOMB  = 2'd2;

  // hash mix multipliers
  localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;

  // datapath operations
  localparam logic [3:0] OP_IDLE   = 4'd0;
  localparam logic [3:0] OP_CLEAR  = 4'd1;
  localparam logic [3:0] OP_LOAD   = 4'd2;
  localparam logic [3:0] OP_MUL    = 4'd3;
  localparam logic [3:0] OP_FIN    = 4'd4;
  localparam logic [3:0] OP_HOME   = 4'd5;
  localparam logic [3:0] OP_STEP   = 4'd6;
  localparam logic [3:0] OP_INSERT = 4'd7;
  localparam logic [3:0] OP_REMOVE = 4'd8;

  // controller -> datapath command
  typedef struct packed {
    logic [3:0] op;
    logic [1:0] step;    // partial product index within one multiply
    logic       rnd;     // which mix multiply (0 first, 1 second)
    logic       emit;    // present a result next cycle
    logic [2:0] status;
  } dp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic key_zero;
    logic tag_empty;
    logic hit;
    logic last;
    logic free_avail;
    logic at_limit;
    logic clear_last;
  } dp_stat_t;

endpackage

>>> rtl/oaps_ctrl.sv
// Controller state machine for the open-addressing pointer set.
// Depends on oaps_pkg; drives oaps_dpath through dp_cmd_t, reads dp_stat_t.
module oaps_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         command,
  input  oaps_pkg::dp_stat_t stat,
  output oaps_pkg::dp_cmd_t  ctl,
  output logic               busy
);
  import oaps_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;
  localparam logic [2:0] S_HOME  = 3'd4;
  localparam logic [2:0] S_WAIT  = 3'd5;
  localparam logic [2:0] S_CHECK = 3'd6;

  logic [2:0] state, state_next;
  logic [1:0] step, step_next;
  logic       rnd, rnd_next;
  logic [1:0] cmd_q;
  logic       stop;

  assign busy = (state != S_IDLE);
  assign stop = stat.tag_empty || stat.hit || stat.last;

  // next state and command
  always_comb begin
    state_next = state;
    step_next  = step;
    rnd_next   = rnd;
    ctl        = '0;
    ctl.op     = OP_IDLE;
    ctl.step   = step;
    ctl.rnd    = rnd;
    ctl.status = ST_ABSENT;
    case (state)
      S_CLEAR: begin
        ctl.op = OP_CLEAR;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (stat.key_zero) begin
            ctl.emit   = 1'b1;
            ctl.status = ST_ZERO;
          end else begin
            ctl.op     = OP_LOAD;
            step_next  = 2'd0;
            rnd_next   = 1'b0;
            state_next = S_MUL;
          end
        end
      end
      S_MUL: begin
        ctl.op    = OP_MUL;
        step_next = step + 2'd1;
        if (step == 2'd2) state_next = S_FIN;
      end
      S_FIN: begin
        ctl.op    = OP_FIN;
        step_next = 2'd0;
        if (!rnd) begin
          rnd_next   = 1'b1;
          state_next = S_MUL;
        end else begin
          state_next = S_HOME;
        end
      end
      S_HOME: begin
        ctl.op     = OP_HOME;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!stop) begin
          ctl.op     = OP_STEP;
          state_next = S_WAIT;
        end else begin
          ctl.emit   = 1'b1;
          state_next = S_IDLE;
          case (cmd_q)
            CMD_INSERT: begin
              if (stat.hit) begin
                ctl.status = ST_ALREADY;
              end else if (stat.at_limit || !stat.free_avail) begin
                ctl.status = ST_FULL;
              end else begin
                ctl.op     = OP_INSERT;
                ctl.status = ST_INSERTED;
              end
            end
            CMD_REMOVE: begin
              if (stat.hit) begin
                ctl.op     = OP_REMOVE;
                ctl.status = ST_REMOVED;
              end else begin
                ctl.status = ST_ABSENT;
              end
            end
            default: begin
              // query, and the unused code behaves as a query
              ctl.status = stat.hit ? ST_PRESENT : ST_ABSENT;
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      step  <= 2'd0;
      rnd   <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      rnd   <= rnd_next;
    end
  end

  // latch the command of an accepted item
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) cmd_q <= command;
  end

  // a result is emitted only from idle (zero key) or from a finished probe
  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> (state == S_IDLE || state == S_CHECK))
    else $error("result emitted outside idle or probe check");

  // the multiply sequence never runs past its third partial product
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (step != 2'd3))
    else $error("multiply step out of range");

  // a probe check is always preceded by a memory read cycle
  a_check_after_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> $past(state == S_WAIT))
    else $error("probe check without read cycle");

endmodule

>>> rtl/oaps_dpath.sv
// Datapath for the open-addressing pointer set: hash unit, slot memories, probe
// registers and live counter. Depends on oaps_pkg; commanded by oaps_ctrl.
module oaps_dpath #(
  parameter int SLOTS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [63:0]        key,
  input  oaps_pkg::dp_cmd_t  ctl,
  output oaps_pkg::dp_stat_t stat,
  output logic               done,
  output logic [2:0]         status,
  output logic [10:0]        live_total
);
  import oaps_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = IDX_W + 1;
  // refuse a new key once (live + 1) * 10 >= SLOTS * 7
  localparam int LIM   = (SLOTS * 7 + 9) / 10 - 1;
  localparam int EXT_W = CNT_W + 11;

  // slot memories
  logic [1:0]  tag_mem [SLOTS];
  logic [63:0] key_mem [SLOTS];

  logic [63:0]      key_reg, h, acc, prod;
  logic [IDX_W-1:0] idx, n, tomb_idx, wr_addr;
  logic             tomb_seen;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [EXT_W-1:0] cnt_ext;
  logic [1:0]       rd_tag, tag_wd;
  logic [63:0]      rd_key;
  logic             tag_we, key_we, hit;
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      mix_c, mul_p, prod_al, fin_r, load_x;

  // hash arithmetic: one 32x32 partial product per cycle
  always_comb begin
    mix_c   = ctl.rnd ? MIX_C2 : MIX_C1;
    mul_a   = (ctl.step == 2'd1) ? h[63:32] : h[31:0];
    mul_b   = (ctl.step == 2'd2) ? mix_c[63:32] : mix_c[31:0];
    mul_p   = 64'(mul_a) * 64'(mul_b);
    // the low product enters whole, the cross products in the upper half
    prod_al = (ctl.step == 2'd1) ? prod : {prod[31:0], 32'd0};
    fin_r   = acc + {prod[31:0], 32'd0};
    load_x  = {3'd0, key[63:3]};
  end

  // hash and key registers
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LOAD: begin
        key_reg <= key;
        h       <= load_x ^ (load_x >> 33);
      end
      OP_MUL: begin
        prod <= mul_p;
        acc  <= (ctl.step == 2'd0) ? 64'd0 : acc + prod_al;
      end
      OP_FIN: begin
        h <= fin_r ^ (fin_r >> 33);
      end
      default: begin
      end
    endcase
  end

  // live counter update
  always_comb begin
    cnt_next = cnt;
    case (ctl.op)
      OP_INSERT: cnt_next = cnt + 1'b1;
      OP_REMOVE: cnt_next = (cnt != '0) ? cnt - 1'b1 : cnt;
      default:   cnt_next = cnt;
    endcase
  end
  assign cnt_ext = {11'd0, cnt_next};

  // probe and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      n         <= '0;
      tomb_seen <= 1'b0;
      cnt       <= '0;
      done      <= 1'b0;
    end else begin
      done <= ctl.emit;
      cnt  <= cnt_next;
      case (ctl.op)
        OP_CLEAR: idx <= idx + 1'b1;
        OP_HOME: begin
          idx       <= h[IDX_W-1:0];
          n         <= '0;
          tomb_seen <= 1'b0;
        end
        OP_STEP: begin
          idx <= idx + 1'b1;
          n   <= n + 1'b1;
          if (rd_tag == TAG_TOMB) tomb_seen <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // first tombstone on the probe path, and result registers
  always_ff @(posedge clk) begin
    if (ctl.op == OP_STEP && rd_tag == TAG_TOMB && !tomb_seen) tomb_idx <= idx;
    if (ctl.emit) begin
      status     <= ctl.status;
      live_total <= cnt_ext[10:0];
    end
  end

  // memory write control
  always_comb begin
    tag_we  = 1'b0;
    key_we  = 1'b0;
    tag_wd  = TAG_EMPTY;
    wr_addr = idx;
    case (ctl.op)
      OP_CLEAR: tag_we = 1'b1;
      OP_INSERT: begin
        tag_we  = 1'b1;
        key_we  = 1'b1;
        tag_wd  = TAG_LIVE;
        wr_addr = tomb_seen ? tomb_idx : idx;
      end
      OP_REMOVE: begin
        tag_we = 1'b1;
        tag_wd = TAG_TOMB;
      end
      default: begin
      end
    endcase
  end

  // slot memories: one write port, registered read at the probe index
  always_ff @(posedge clk) begin
    rd_tag <= tag_mem[idx];
    rd_key <= key_mem[idx];
    if (tag_we) tag_mem[wr_addr] <= tag_wd;
    if (key_we) key_mem[wr_addr] <= key_reg;
  end

  // status to controller
  assign hit = (rd_tag == TAG_LIVE) && (rd_key == key_reg);
  always_comb begin
    stat.key_zero   = (key == 64'd0);
    stat.tag_empty  = (rd_tag == TAG_EMPTY);
    stat.hit        = hit;
    stat.last       = &n;
    stat.free_avail = tomb_seen || (rd_tag != TAG_LIVE);
    stat.at_limit   = (cnt >= CNT_W'(LIM));
    stat.clear_last = &idx;
  end

  // the live count never passes the load limit
  a_cnt_limit: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(LIM))
    else $error("live count above load limit");

  // an insert only lands in a free slot below the load limit
  a_insert_ok: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_INSERT) |-> (stat.free_avail && !stat.at_limit && !hit))
    else $error("insert without free slot");

  // a remove only hits a live matching slot and lowers the count by one
  a_remove_ok: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_REMOVE) |-> hit ##1 (cnt == $past(cnt) - 1'b1))
    else $error("remove without live hit");

endmodule

>>> rtl/open_addressing_pointer_set_unit.sv
// Open-addressing pointer set: 64-bit keys, linear probing with tombstones.
// After acceptance: key load, both mix multiplies with their finish steps, home index,
// then per slot probed (1 to SLOTS) a registered tag/key read and a compare, then done.
// A zero key answers next cycle. busy falls as done rises; the receiver cannot stall.
// Reset: synchronous; a clearing pass over every slot empties the tag memory, busy high.
// Depends on oaps_pkg, oaps_ctrl, oaps_dpath.
module open_addressing_pointer_set_unit #(
  parameter int SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [63:0] key,
  output logic        done,
  output logic [2:0]  status,
  output logic [10:0] live_total
);
  import oaps_pkg::*;

  dp_cmd_t  ctl;
  dp_stat_t stat;

  oaps_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (stat),
    .ctl     (ctl),
    .busy    (busy)
  );

  oaps_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .key        (key),
    .ctl        (ctl),
    .stat       (stat),
    .done       (done),
    .status     (status),
    .live_total (live_total)
  );

endmodule

>>> tb/sv/open_addressing_pointer_set_unit_tb.sv
// Self-checking testbench for open_addressing_pointer_set_unit: directed and random
// insert/query/remove items, checked against a scoreboard that mirrors the probe table.
// Depends on oaps_pkg and the open_addressing_pointer_set_unit RTL.
module open_addressing_pointer_set_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import oaps_pkg::*;

  localparam int SLOTS = 1024;
  localparam logic [1:0] CMD_SPARE = 2'd3;  // unused code, answers like a query
  localparam int QUIET_LIMIT = 20000;       // > clearing pass and a full-wrap probe
  localparam int TAIL_CYCLES = 40;
  localparam int POOL_SIZE = 96;
  localparam int MAX_SHOWN = 40;

  typedef struct packed {
    logic [2:0]  status;
    logic [10:0] live;
  } outcome_t;

  // Scoreboard: own copy of the slot table, predicts one outcome per item
  class pointer_set_board;
    logic [63:0] keys_held [SLOTS];
    logic [1:0]  tags_held [SLOTS];
    int live_keys;
    int peak_live;
    int longest_walk;
    int results_seen;
    int errors;
    int status_seen [7];
    outcome_t owed [$];

    function new();
      foreach (tags_held[i]) begin
        tags_held[i] = TAG_EMPTY;
        keys_held[i] = '0;
      end
      foreach (status_seen[i]) status_seen[i] = 0;
      live_keys = 0;
      peak_live = 0;
      longest_walk = 0;
      results_seen = 0;
      errors = 0;
    endfunction

    // home slot: key >> 3, two-multiply mix, masked to the table size
    function int home_of(logic [63:0] k);
      logic [63:0] h;
      h = k >> 3;
      h = h ^ (h >> 33);
      h = h * MIX_C1;
      h = h ^ (h >> 33);
      h = h * MIX_C2;
      h = h ^ (h >> 33);
      return int'(h & 64'(SLOTS - 1));
    endfunction

    // linear probe; stops at an empty slot, a live match, or after one wrap
    function void walk(input logic [63:0] k, output int hit, output int tomb,
                       output int hole);
      int i;
      int n;
      i = home_of(k);
      hit = -1;
      tomb = -1;
      hole = -1;
      for (n = 0; n < SLOTS; n++) begin
        if (tags_held[i] == TAG_EMPTY) begin
          hole = i;
          break;
        end
        if (tags_held[i] == TAG_LIVE && keys_held[i] == k) begin
          hit = i;
          break;
        end
        if (tags_held[i] == TAG_TOMB && tomb < 0) tomb = i;
        i = (i + 1 == SLOTS) ? 0 : i + 1;
      end
      if (n + 1 > longest_walk) longest_walk = (n < SLOTS) ? n + 1 : SLOTS;
    endfunction

    // accepted item: update the table and queue the outcome it owes
    function void note_item(logic [1:0] cmd, logic [63:0] k);
      int hit;
      int tomb;
      int hole;
      int spot;
      logic [2:0] st;
      outcome_t o;
      if (k == '0) begin
        st = ST_ZERO;
      end else begin
        walk(k, hit, tomb, hole);
        case (cmd)
          CMD_INSERT: begin
            if (hit >= 0) begin
              st = ST_ALREADY;
            end else if ((live_keys + 1) * 10 >= SLOTS * 7) begin
              st = ST_FULL;
            end else begin
              spot = (tomb >= 0) ? tomb : hole;
              if (spot < 0) begin
                st = ST_FULL;
              end else begin
                keys_held[spot] = k;
                tags_held[spot] = TAG_LIVE;
                live_keys++;
                st = ST_INSERTED;
              end
            end
          end
          CMD_REMOVE: begin
            if (hit >= 0) begin
              tags_held[hit] = TAG_TOMB;
              if (live_keys > 0) live_keys--;
              st = ST_REMOVED;
            end else begin
              st = ST_ABSENT;
            end
          end
          default: st = (hit >= 0) ? ST_PRESENT : ST_ABSENT;
        endcase
      end
      if (live_keys > peak_live) peak_live = live_keys;
      status_seen[st]++;
      o.status = st;
      o.live = live_keys[10:0];
      owed.push_back(o);
    endfunction

    // a key currently in the set, or a fresh one if the set is empty
    function logic [63:0] pick_live();
      int i;
      if (live_keys == 0) return {$urandom, $urandom} | 64'h8;
      i = $urandom_range(0, SLOTS - 1);
      while (tags_held[i] != TAG_LIVE) i = (i + 1 == SLOTS) ? 0 : i + 1;
      return keys_held[i];
    endfunction

    function int pending();
      return owed.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_SHOWN) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic [2:0] st, logic [10:0] live);
      outcome_t want;
      results_seen++;
      if (owed.size() == 0) begin
        report($sformatf("result with nothing pending: status %0d live %0d", st, live));
        return;
      end
      want = owed.pop_front();
      if (st !== want.status)
        report($sformatf("status %0d, want %0d", st, want.status));
      if (live !== want.live)
        report($sformatf("live_total %0d, want %0d", live, want.live));
    endtask

    task finish_check();
      if (owed.size() != 0)
        report($sformatf("%0d results never arrived", owed.size()));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic [1:0]  command;
  logic [63:0] key;
  wire         busy;
  wire         done;
  wire  [2:0]  status;
  wire  [10:0] live_total;

  pointer_set_board sb;
  logic [63:0] pool_base [POOL_SIZE];
  int items_sent;
  int calm_left;
  int quiet;

  open_addressing_pointer_set_unit #(
    .SLOTS(SLOTS)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .key        (key),
    .done       (done),
    .status     (status),
    .live_total (live_total)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // sender gap: mostly none or short, a few long, with calm stretches
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // random key, half of them 8-byte aligned like a pointer
  function automatic logic [63:0] fresh_key();
    logic [63:0] k;
    k = {$urandom, $urandom};
    if ($urandom_range(0, 1) == 0) k[2:0] = 3'b000;
    return k;
  endfunction

  // key from a small pool; low bits vary so several keys share a home slot
  function automatic logic [63:0] pool_key();
    logic [63:0] k;
    k = pool_base[$urandom_range(0, POOL_SIZE - 1)];
    if ($urandom_range(0, 1) == 0) k[2:0] = 3'($urandom_range(1, 7));
    return k;
  endfunction

  function automatic logic [1:0] mixed_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return CMD_INSERT;
    if (r < 65) return CMD_QUERY;
    if (r < 95) return CMD_REMOVE;
    return CMD_SPARE;
  endfunction

  // present one item and hold it until the block takes it
  task automatic send_item(input logic [1:0] cmd, input logic [63:0] k);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    command <= cmd;
    key     <= k;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_item(cmd, k);
    items_sent++;
  endtask

  // result monitor
  always @(posedge clk) begin
    if (rst === 1'b0 && done === 1'b1) sb.check_result(status, live_total);
  end

  // watchdog: no item taken and no result for too long
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
      quiet = 0;
    end else begin
      quiet = quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: %0d quiet cycles, %0d results pending", quiet, sb.pending());
      $display("open_addressing_pointer_set_unit_tb: errors");
      $finish;
    end
  end

  initial begin
    logic [63:0] grp;
    int r;
    int guard;
    sb = new();
    items_sent = 0;
    calm_left = 0;
    quiet = 0;
    foreach (pool_base[i]) pool_base[i] = {$urandom, $urandom} & ~64'h7;
    rst     <= 1'b1;
    start   <= 1'b0;
    command <= CMD_QUERY;
    key     <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: zero key on every command, collisions, tombstone reuse, extremes
    grp = 64'h0000_7f00_1234_5670;
    send_item(CMD_INSERT, 64'd0);
    send_item(CMD_QUERY, 64'd0);
    send_item(CMD_REMOVE, 64'd0);
    send_item(CMD_SPARE, 64'd0);
    send_item(CMD_QUERY, grp);
    send_item(CMD_INSERT, grp);
    send_item(CMD_INSERT, grp);
    send_item(CMD_QUERY, grp);
    send_item(CMD_INSERT, grp | 64'd1);
    send_item(CMD_INSERT, grp | 64'd2);
    send_item(CMD_REMOVE, grp);
    send_item(CMD_QUERY, grp | 64'd2);
    send_item(CMD_REMOVE, grp);
    send_item(CMD_INSERT, grp | 64'd3);
    send_item(CMD_SPARE, grp | 64'd3);
    send_item(CMD_INSERT, '1);
    send_item(CMD_SPARE, '1);
    send_item(CMD_INSERT, 64'h8000_0000_0000_0000);
    send_item(CMD_INSERT, 64'd1);
    send_item(CMD_INSERT, 64'd7);
    send_item(CMD_REMOVE, 64'd1);
    send_item(CMD_QUERY, 64'd7);
    send_item(CMD_REMOVE, 64'd7);
    send_item(CMD_QUERY, 64'd7);
    send_item(CMD_REMOVE, '1);

    // low load: mixed commands over a colliding pool, some fresh and zero keys
    repeat (450) begin
      r = $urandom_range(0, 99);
      if (r < 75) send_item(mixed_cmd(), pool_key());
      else if (r < 95) send_item(mixed_cmd(), fresh_key());
      else send_item(mixed_cmd(), 64'd0);
    end

    // fill up to the load limit, mostly new keys
    guard = 0;
    while (sb.live_keys * 10 < SLOTS * 7 - 10 && guard < 1100) begin
      r = $urandom_range(0, 99);
      if (r < 85) send_item(CMD_INSERT, fresh_key());
      else if (r < 95) send_item(CMD_QUERY, pool_key());
      else send_item(CMD_REMOVE, pool_key());
      guard++;
    end

    // at the limit: refused inserts, re-inserts, removes that free room again
    repeat (250) begin
      r = $urandom_range(0, 99);
      if (r < 30) send_item(CMD_INSERT, fresh_key());
      else if (r < 50) send_item(CMD_INSERT, sb.pick_live());
      else if (r < 75) send_item(CMD_REMOVE, sb.pick_live());
      else if (r < 85) send_item(CMD_QUERY, sb.pick_live());
      else if (r < 90) send_item(CMD_QUERY, fresh_key());
      else if (r < 95) send_item(2'($urandom_range(CMD_INSERT, CMD_SPARE)), 64'd0);
      else send_item(CMD_SPARE, sb.pick_live());
    end

    // drain
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.finish_check();

    $display("ran %0d items, checked %0d results; peak %0d live keys, probes up to %0d slots",
             items_sent, sb.results_seen, sb.peak_live, sb.longest_walk);
    $display("outcomes: inserted %0d already %0d present %0d absent %0d removed %0d zero %0d full %0d",
             sb.status_seen[ST_INSERTED], sb.status_seen[ST_ALREADY],
             sb.status_seen[ST_PRESENT], sb.status_seen[ST_ABSENT],
             sb.status_seen[ST_REMOVED], sb.status_seen[ST_ZERO], sb.status_seen[ST_FULL]);
    if (sb.errors == 0) begin
      $display("open_addressing_pointer_set_unit_tb: clean");
    end else begin
      $display("open_addressing_pointer_set_unit_tb: errors");
    end
    $finish;
  end

endmodule
